/* rtl/ik2tb_pkg.sv */
// Package for the interleaved k2-tree builder: default sizes, codes, the
// result word type and the constant functions that size the tree.
// No dependencies.
`default_nettype none

package ik2tb_pkg;

  localparam int GridDefault      = 16;
  localparam int BranchDefault    = 2;
  localparam int SnapshotsDefault = 4;

  localparam int WordW  = 64;
  localparam int CountW = 7;
  localparam int CfgW   = 3;

  // Configuration register indexes.
  localparam logic CFG_SNAP_COUNT = 1'b0;
  localparam logic CFG_DIFF_MODE  = 1'b1;

  localparam logic [CfgW-1:0] SnapCountReset = 3'd4;

  // Input opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
    logic              section;
  } pword_t;

  function automatic int ipow(input int b, input int e);
    int r;
    r = 1;
    for (int k = 0; k < e; k++) begin
      r = r * b;
    end
    return r;
  endfunction

  // Number of tree levels: the smallest exponent of the branching factor
  // whose power covers the grid, at least one level.
  function automatic int calc_depth(input int g, input int b);
    int side;
    int d;
    side = 1;
    d = 0;
    while (side < g) begin
      side = side * b;
      d++;
    end
    if (d == 0) begin
      d = 1;
    end
    return d;
  endfunction

  // First entry of level lvl (root is level 1) in a level-major node table.
  function automatic int level_base(input int kk, input int lvl);
    int r;
    r = 0;
    for (int l = 1; l < lvl; l++) begin
      r = r + ipow(kk, l - 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/interleaved_k2_tree_builder_unit.sv */
// Interleaved k2-tree builder: adjacency bit store, node occupancy table,
// bottom-up occupancy pass and top-down emission packer.
// Depends on ik2tb_pkg.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   opcode, snapshot, row, column, edge_req
// out       source     out_valid_o / out_stall_i word, bit_count, section, last_word
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A load transfer is written into the adjacency memory in the cycle it is
// taken, so loads stream at one per cycle. A build holds the input stalled;
// each memory read has a read state and a use state. The occupancy pass
// visits every cell and every node below the root, then emission visits
// each node and each child of a nonempty node; a stalled output holds
// emission. Reset clears the adjacency valid bits at once, so no clearing
// pass is needed. Output words pass through a one-word hold stage so the
// final word can be flagged.

module interleaved_k2_tree_builder_unit
  import ik2tb_pkg::*;
#(
  parameter int GRID      = GridDefault,
  parameter int BRANCH    = BranchDefault,
  parameter int SNAPSHOTS = SnapshotsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              opcode_i,
  input  wire logic [1:0]        snapshot_i,
  input  wire logic [3:0]        row_i,
  input  wire logic [3:0]        column_i,
  input  wire logic              edge_req_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WordW-1:0]       word_o,
  output logic [CountW-1:0]      bit_count_o,
  output logic                   section_o,
  output logic                   last_word_o,

  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [CfgW-1:0]   cfg_data_i
);

  localparam int KK         = BRANCH * BRANCH;
  localparam int DEPTH      = calc_depth(GRID, BRANCH);
  localparam int SIDE       = ipow(BRANCH, DEPTH);
  localparam int NODES      = level_base(KK, DEPTH + 1);
  localparam int LEAF_NODES = ipow(KK, DEPTH - 1);
  localparam int LVL_W      = $clog2(DEPTH + 1);
  localparam int NODE_W     = (LEAF_NODES > 1) ? $clog2(LEAF_NODES) : 1;
  localparam int KID_W      = $clog2(KK);
  localparam int OADDR_W    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CADDR_W    = $clog2(NODES + 1);
  localparam int DIG_W      = $clog2(BRANCH);
  localparam int POS_W      = $clog2(SIDE);
  localparam int ADJ_DEPTH  = GRID * GRID;
  localparam int ADJ_W      = $clog2(ADJ_DEPTH);
  localparam int SI_W       = (SNAPSHOTS > 1) ? $clog2(SNAPSHOTS) : 1;
  localparam int SC_W       = $clog2(SNAPSHOTS + 1);
  localparam int EXT_W      = WordW + SNAPSHOTS;
  localparam int FILL_W     = $clog2(WordW);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_LRD    = 11'b000_0000_0010,
    ST_LUS    = 11'b000_0000_0100,
    ST_URD    = 11'b000_0000_1000,
    ST_UUS    = 11'b000_0001_0000,
    ST_ENRD   = 11'b000_0010_0000,
    ST_ENUS   = 11'b000_0100_0000,
    ST_ECRD   = 11'b000_1000_0000,
    ST_ECUS   = 11'b001_0000_0000,
    ST_EFLUSH = 11'b010_0000_0000,
    ST_EFIN   = 11'b100_0000_0000
  } state_e;

  // The empty-graph result and the normal end of emission share the final state.
  typedef enum logic [1:0] {
    FIN_NONE  = 2'b01,
    FIN_EMPTY = 2'b10
  } fin_e;

  state_e state_q, state_d;
  fin_e   fin_q, fin_d;

  logic [CfgW-1:0]        cnt_q, cnt_d;
  logic                   diff_q, diff_d;

  logic [LVL_W-1:0]       lvl_q, lvl_d;
  logic [NODE_W-1:0]      node_q, node_d;
  logic [KID_W-1:0]       kid_q, kid_d;
  logic [CADDR_W-1:0]     naddr_q, naddr_d;
  logic [CADDR_W-1:0]     caddr_q, caddr_d;
  logic [SNAPSHOTS-1:0]   acc_q, acc_d;
  logic [SNAPSHOTS-1:0]   nocc_q, nocc_d;
  logic [DIG_W-1:0]       di_q [DEPTH];
  logic [DIG_W-1:0]       dj_q [DEPTH];
  logic [DIG_W-1:0]       di_d [DEPTH];
  logic [DIG_W-1:0]       dj_d [DEPTH];
  logic [WordW-1:0]       pack_q, pack_d;
  logic [FILL_W-1:0]      fill_q, fill_d;

  pword_t                 hold_q, hold_d;
  logic                   hold_v_q, hold_v_d;
  pword_t                 out_q, out_d;
  logic                   out_last_q, out_last_d;
  logic                   out_v_q, out_v_d;

  // Memories.
  logic [SNAPSHOTS-1:0]   adj_mem [ADJ_DEPTH];
  logic [ADJ_DEPTH-1:0]   adj_vld_q;
  logic [SNAPSHOTS-1:0]   adj_rd_q;
  logic                   vld_rd_q;
  logic                   inr_q;
  logic [SNAPSHOTS-1:0]   occ_mem [NODES];
  logic [SNAPSHOTS-1:0]   occ_rd_q;

  logic                   in_take;
  logic                   ld_we;
  logic [ADJ_W-1:0]       ld_adr;
  logic [SI_W-1:0]        ld_snap;
  logic [SNAPSHOTS-1:0]   ld_word;

  logic [POS_W-1:0]       cell_row;
  logic [POS_W-1:0]       cell_col;
  logic                   cell_inr;
  logic [ADJ_W-1:0]       cell_adr;
  logic                   adj_re;
  logic                   occ_re;
  logic [OADDR_W-1:0]     occ_ra;
  logic                   occ_we;
  logic [OADDR_W-1:0]     occ_wa;
  logic [SNAPSHOTS-1:0]   occ_wd;

  logic [SC_W-1:0]        snaps_used;
  logic [SNAPSHOTS-1:0]   snap_mask;
  logic [SNAPSHOTS-1:0]   raw;
  logic [SNAPSHOTS-1:0]   cellv;
  logic [SNAPSHOTS-1:0]   childv;
  logic [SNAPSHOTS-1:0]   sel;
  logic [SNAPSHOTS-1:0]   tmp_bits;
  logic [SC_W-1:0]        tmp_cnt;
  logic [EXT_W-1:0]       ext;
  logic [CountW-1:0]      new_fill;
  logic [SNAPSHOTS-1:0]   acc_nx;

  logic [NODE_W-1:0]      nlast;
  logic [CADDR_W-1:0]     base_cur;
  logic [CADDR_W-1:0]     base_dn;
  logic                   is_leaf;
  logic                   is_root;
  logic                   node_last;
  logic                   kid_last;
  logic                   out_free;
  logic                   room;
  logic                   adv;
  logic                   start_emit;
  logic                   prod_v;
  pword_t                 prod;

  logic [DIG_W-1:0]       st_di [DEPTH];
  logic [DIG_W-1:0]       st_dj [DEPTH];
  logic [DIG_W-1:0]       sk_di [DEPTH];
  logic [DIG_W-1:0]       sk_dj [DEPTH];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign word_o      = out_q.word;
  assign bit_count_o = out_q.count;
  assign section_o   = out_q.section;
  assign last_word_o = out_last_q;

  // Load path.
  assign in_take = in_valid_i && !in_stall_o;
  assign ld_snap = snapshot_i[SI_W-1:0];
  assign ld_adr  = ADJ_W'(int'(row_i) * GRID + int'(column_i));
  assign ld_word = SNAPSHOTS'(edge_req_i) << ld_snap;
  assign ld_we   = in_take && (opcode_i == OP_LOAD) && (int'(snapshot_i) < SNAPSHOTS) &&
                   (int'(row_i) < GRID) && (int'(column_i) < GRID);

  // Level-dependent constants and the cell position of the digit counter.
  always_comb begin
    nlast    = '0;
    base_cur = '0;
    base_dn  = '0;
    for (int k = 1; k <= DEPTH; k++) begin
      if (lvl_q == LVL_W'(k)) begin
        nlast    = NODE_W'(ipow(KK, k - 1) - 1);
        base_cur = CADDR_W'(level_base(KK, k));
        base_dn  = CADDR_W'(level_base(KK, k - 1));
      end
    end
    cell_row = '0;
    cell_col = '0;
    for (int k = 0; k < DEPTH; k++) begin
      cell_row = cell_row + POS_W'(di_q[k]) * POS_W'(ipow(BRANCH, DEPTH - 1 - k));
      cell_col = cell_col + POS_W'(dj_q[k]) * POS_W'(ipow(BRANCH, DEPTH - 1 - k));
    end
  end

  assign cell_inr  = (int'(cell_row) < GRID) && (int'(cell_col) < GRID);
  assign cell_adr  = ADJ_W'(int'(cell_row) * GRID + int'(cell_col));
  assign is_leaf   = (lvl_q == LVL_W'(DEPTH));
  assign is_root   = (lvl_q == LVL_W'(1));
  assign node_last = (node_q == nlast);
  assign kid_last  = (kid_q == KID_W'(KK - 1));
  assign out_free  = !out_v_q || !out_stall_i;
  assign room      = !hold_v_q || out_free;

  // Digit counter: one step per cell, or a skip over a whole leaf node.
  always_comb begin
    logic c_st;
    logic c_sk;
    c_st = 1'b1;
    c_sk = 1'b1;
    for (int k = 0; k < DEPTH; k++) begin
      st_di[k] = di_q[k];
      st_dj[k] = dj_q[k];
      sk_di[k] = di_q[k];
      sk_dj[k] = dj_q[k];
    end
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (c_st) begin
        if (dj_q[k] == DIG_W'(BRANCH - 1)) begin
          st_dj[k] = '0;
          if (di_q[k] == DIG_W'(BRANCH - 1)) begin
            st_di[k] = '0;
          end else begin
            st_di[k] = di_q[k] + 1'b1;
            c_st = 1'b0;
          end
        end else begin
          st_dj[k] = dj_q[k] + 1'b1;
          c_st = 1'b0;
        end
      end
      if (c_sk && (k <= DEPTH - 2)) begin
        if (dj_q[k] == DIG_W'(BRANCH - 1)) begin
          sk_dj[k] = '0;
          if (di_q[k] == DIG_W'(BRANCH - 1)) begin
            sk_di[k] = '0;
          end else begin
            sk_di[k] = di_q[k] + 1'b1;
            c_sk = 1'b0;
          end
        end else begin
          sk_dj[k] = dj_q[k] + 1'b1;
          c_sk = 1'b0;
        end
      end
    end
  end

  // Snapshot selection, difference coding and bit compaction.
  always_comb begin
    if (cnt_q == '0) begin
      snaps_used = SC_W'(1);
    end else if (int'(cnt_q) > SNAPSHOTS) begin
      snaps_used = SC_W'(SNAPSHOTS);
    end else begin
      snaps_used = SC_W'(cnt_q);
    end
    for (int m = 0; m < SNAPSHOTS; m++) begin
      snap_mask[m] = (SC_W'(m) < snaps_used);
    end
    raw = vld_rd_q ? adj_rd_q : '0;
    for (int m = 0; m < SNAPSHOTS; m++) begin
      if (m > 0) begin
        cellv[m] = raw[m] ^ (diff_q & raw[(m > 0) ? m - 1 : 0]);
      end else begin
        cellv[m] = raw[m];
      end
    end
    cellv  = cellv & snap_mask & {SNAPSHOTS{inr_q}};
    childv = is_leaf ? cellv : occ_rd_q;
    sel    = (is_root ? {SNAPSHOTS{1'b1}} : nocc_q) & snap_mask;
    tmp_bits = '0;
    tmp_cnt  = '0;
    for (int m = 0; m < SNAPSHOTS; m++) begin
      if (sel[m]) begin
        tmp_bits[tmp_cnt[SI_W-1:0]] = childv[m];
        tmp_cnt = tmp_cnt + 1'b1;
      end
    end
    ext      = EXT_W'(pack_q) | (EXT_W'(tmp_bits) << fill_q);
    new_fill = CountW'(fill_q) + CountW'(tmp_cnt);
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    cnt_d      = cnt_q;
    diff_d     = diff_q;
    lvl_d      = lvl_q;
    node_d     = node_q;
    kid_d      = kid_q;
    naddr_d    = naddr_q;
    caddr_d    = caddr_q;
    acc_d      = acc_q;
    nocc_d     = nocc_q;
    pack_d     = pack_q;
    fill_d     = fill_q;
    hold_d     = hold_q;
    hold_v_d   = hold_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_v_d    = out_v_q;
    for (int k = 0; k < DEPTH; k++) begin
      di_d[k] = di_q[k];
      dj_d[k] = dj_q[k];
    end
    adj_re     = 1'b0;
    occ_re     = 1'b0;
    occ_ra     = naddr_q[OADDR_W-1:0];
    occ_we     = 1'b0;
    occ_wa     = naddr_q[OADDR_W-1:0];
    acc_nx     = acc_q | (is_leaf ? cellv : occ_rd_q);
    occ_wd     = acc_nx;
    adv        = 1'b0;
    start_emit = 1'b0;
    prod_v     = 1'b0;
    prod       = '0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SNAP_COUNT: cnt_d  = cfg_data_i;
        CFG_DIFF_MODE:  diff_d = cfg_data_i[0];
        default:        cnt_d  = cnt_q;
      endcase
    end

    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_take && (opcode_i == OP_BUILD)) begin
          lvl_d   = LVL_W'(DEPTH);
          node_d  = '0;
          kid_d   = '0;
          naddr_d = CADDR_W'(level_base(KK, DEPTH));
          acc_d   = '0;
          for (int k = 0; k < DEPTH; k++) begin
            di_d[k] = '0;
            dj_d[k] = '0;
          end
          state_d = ST_LRD;
        end
      end
      ST_LRD: begin
        adj_re  = 1'b1;
        state_d = ST_LUS;
      end
      ST_LUS: begin
        for (int k = 0; k < DEPTH; k++) begin
          di_d[k] = st_di[k];
          dj_d[k] = st_dj[k];
        end
        state_d = ST_LRD;
        if (kid_last) begin
          occ_we  = 1'b1;
          acc_d   = '0;
          kid_d   = '0;
          naddr_d = naddr_q + 1'b1;
          node_d  = node_q + 1'b1;
          if (node_last) begin
            node_d = '0;
            if (is_root) begin
              start_emit = 1'b1;
            end else begin
              lvl_d   = lvl_q - 1'b1;
              naddr_d = base_dn;
              caddr_d = base_cur;
              state_d = ST_URD;
            end
          end
        end else begin
          acc_d = acc_nx;
          kid_d = kid_q + 1'b1;
        end
      end
      ST_URD: begin
        occ_re  = 1'b1;
        occ_ra  = caddr_q[OADDR_W-1:0];
        state_d = ST_UUS;
      end
      ST_UUS: begin
        caddr_d = caddr_q + 1'b1;
        state_d = ST_URD;
        if (kid_last) begin
          occ_we  = 1'b1;
          acc_d   = '0;
          kid_d   = '0;
          naddr_d = naddr_q + 1'b1;
          node_d  = node_q + 1'b1;
          if (node_last) begin
            node_d = '0;
            if (is_root) begin
              start_emit = 1'b1;
            end else begin
              lvl_d   = lvl_q - 1'b1;
              naddr_d = base_dn;
              caddr_d = base_cur;
            end
          end
        end else begin
          acc_d = acc_nx;
          kid_d = kid_q + 1'b1;
        end
      end
      ST_ENRD: begin
        occ_re  = 1'b1;
        state_d = ST_ENUS;
      end
      ST_ENUS: begin
        nocc_d  = occ_rd_q;
        kid_d   = '0;
        state_d = ST_ECRD;
        if (occ_rd_q == '0) begin
          if (is_root) begin
            fin_d   = FIN_EMPTY;
            state_d = ST_EFIN;
          end else begin
            // Empty node: its children are passed over without reads.
            if (is_leaf) begin
              for (int k = 0; k < DEPTH; k++) begin
                di_d[k] = sk_di[k];
                dj_d[k] = sk_dj[k];
              end
            end else begin
              caddr_d = caddr_q + CADDR_W'(KK);
            end
            adv = 1'b1;
          end
        end
      end
      ST_ECRD: begin
        if (is_leaf) begin
          adj_re = 1'b1;
        end else begin
          occ_re = 1'b1;
          occ_ra = caddr_q[OADDR_W-1:0];
        end
        state_d = ST_ECUS;
      end
      ST_ECUS: begin
        if (room) begin
          if (new_fill[CountW-1]) begin
            prod_v       = 1'b1;
            prod.word    = ext[WordW-1:0];
            prod.count   = CountW'(WordW);
            prod.section = is_leaf;
            pack_d       = WordW'(ext >> WordW);
          end else begin
            pack_d = ext[WordW-1:0];
          end
          fill_d = new_fill[FILL_W-1:0];
          if (is_leaf) begin
            for (int k = 0; k < DEPTH; k++) begin
              di_d[k] = st_di[k];
              dj_d[k] = st_dj[k];
            end
          end else begin
            caddr_d = caddr_q + 1'b1;
          end
          if (kid_last) begin
            kid_d = '0;
            adv   = 1'b1;
          end else begin
            kid_d   = kid_q + 1'b1;
            state_d = ST_ECRD;
          end
        end
      end
      ST_EFLUSH: begin
        if (room) begin
          if (fill_q != '0) begin
            prod_v       = 1'b1;
            prod.word    = pack_q;
            prod.count   = CountW'(fill_q);
            prod.section = is_leaf;
          end
          pack_d = '0;
          fill_d = '0;
          if (is_leaf) begin
            fin_d   = FIN_NONE;
            state_d = ST_EFIN;
          end else begin
            lvl_d   = lvl_q + 1'b1;
            state_d = ST_ENRD;
          end
        end
      end
      ST_EFIN: begin
        if (fin_q == FIN_EMPTY) begin
          if (out_free) begin
            out_d         = '0;
            out_d.section = 1'b1;
            out_last_d    = 1'b1;
            out_v_d       = 1'b1;
            state_d       = ST_IDLE;
          end
        end else if (!hold_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d      = hold_q;
          out_last_d = 1'b1;
          out_v_d    = 1'b1;
          hold_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Move on to the next node of the level, or close the level.
    if (adv) begin
      naddr_d = naddr_q + 1'b1;
      node_d  = node_q + 1'b1;
      state_d = ST_ENRD;
      if (node_last) begin
        node_d = '0;
        if (is_leaf || (lvl_q == LVL_W'(DEPTH - 1))) begin
          state_d = ST_EFLUSH;
        end else begin
          lvl_d = lvl_q + 1'b1;
        end
      end
    end

    if (start_emit) begin
      lvl_d   = LVL_W'(1);
      node_d  = '0;
      kid_d   = '0;
      naddr_d = '0;
      caddr_d = CADDR_W'(level_base(KK, 2));
      pack_d  = '0;
      fill_d  = '0;
      for (int k = 0; k < DEPTH; k++) begin
        di_d[k] = '0;
        dj_d[k] = '0;
      end
      state_d = ST_ENRD;
    end

    // A new word pushes the held one out; the held word is the final one
    // only once the build ends.
    if (prod_v) begin
      if (hold_v_q) begin
        out_d      = hold_q;
        out_last_d = 1'b0;
        out_v_d    = 1'b1;
      end
      hold_d   = prod;
      hold_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fin_q     <= FIN_NONE;
      cnt_q     <= SnapCountReset;
      diff_q    <= 1'b0;
      lvl_q     <= '0;
      node_q    <= '0;
      kid_q     <= '0;
      naddr_q   <= '0;
      caddr_q   <= '0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      adj_vld_q <= '0;
    end else begin
      state_q  <= state_d;
      fin_q    <= fin_d;
      cnt_q    <= cnt_d;
      diff_q   <= diff_d;
      lvl_q    <= lvl_d;
      node_q   <= node_d;
      kid_q    <= kid_d;
      naddr_q  <= naddr_d;
      caddr_q  <= caddr_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      if (ld_we) begin
        adj_vld_q[ld_adr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    nocc_q     <= nocc_d;
    pack_q     <= pack_d;
    fill_q     <= fill_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    for (int k = 0; k < DEPTH; k++) begin
      di_q[k] <= di_d[k];
      dj_q[k] <= dj_d[k];
    end
  end

  // Adjacency memory: a word per cell, one bit per snapshot. The first
  // write of a cell writes the whole word so unwritten snapshots read zero.
  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      if (!adj_vld_q[ld_adr]) begin
        adj_mem[ld_adr] <= ld_word;
      end else begin
        adj_mem[ld_adr][ld_snap] <= edge_req_i;
      end
    end
    if (adj_re) begin
      adj_rd_q <= adj_mem[cell_adr];
      vld_rd_q <= adj_vld_q[cell_adr];
      inr_q    <= cell_inr;
    end
  end

  // Node occupancy memory, level-major, root at entry zero.
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    if (occ_re) begin
      occ_rd_q <= occ_mem[occ_ra];
    end
  end

endmodule

`default_nettype wire
